@@ hdl/crfd_pkg.sv @@
package crfd_pkg;

    localparam logic [7:0]  HEAD_BYTE      = 8'h30;
    localparam logic [7:0]  TAIL_BYTE      = 8'h0A;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd8;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd256;

    // Byte positions of the fixed header fields.
    localparam logic [15:0] POS_HEAD       = 16'd0;
    localparam logic [15:0] POS_COMMAND    = 16'd1;
    localparam logic [15:0] POS_LEN_LO     = 16'd2;
    localparam logic [15:0] POS_LEN_HI     = 16'd3;
    localparam logic [15:0] POS_SUBCOMMAND = 16'd4;
    localparam logic [15:0] POS_PAYLOAD    = 16'd5;
    // The CRC runs this many bytes behind the input stream.
    localparam logic [15:0] CRC_LAG        = 16'd3;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG = 3'd2;
    localparam logic [2:0] ERR_HEAD     = 3'd3;
    localparam logic [2:0] ERR_TAIL     = 3'd4;
    localparam logic [2:0] ERR_CRC      = 3'd5;
    localparam logic [2:0] ERR_LENGTH   = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        emit;
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic        frame_ok;
        logic [2:0]  error_code;
        logic [7:0]  command;
        logic [7:0]  subcommand;
        logic [15:0] payload_len;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/crfd_in_if.sv @@
interface crfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ hdl/crfd_out_if.sv @@
interface crfd_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  command;
    logic [7:0]  subcommand;
    logic [15:0] payload_len;

    modport source (output valid, output out_kind, output payload_byte, output frame_ok,
                    output error_code, output command, output subcommand,
                    output payload_len, input ready);
    modport sink (input valid, input out_kind, input payload_byte, input frame_ok,
                  input error_code, input command, input subcommand,
                  input payload_len, output ready);
endinterface

@@ hdl/crfd_frame_core.sv @@
module crfd_frame_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          step_byte,
    input  logic                step_last,
    input  logic [15:0]         max_frame_len,
    output crfd_pkg::result_t   result
);
    import crfd_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  recent_reg [0:2];
    logic [7:0]  recent_next [0:2];
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  subcommand_reg, subcommand_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic        overlong_reg, overlong_next;

    logic        count_sat;
    logic [15:0] total;
    logic [15:0] crc_rx;
    logic [2:0]  err;
    logic        in_payload;

    always_comb
    begin
        count_sat       = &byte_count_reg;
        byte_count_next = count_sat ? byte_count_reg : byte_count_reg + 16'd1;
        total           = byte_count_next;
        overlong_next   = overlong_reg | count_sat;

        crc_next = (byte_count_reg >= CRC_LAG) ? crc_feed(crc_reg, recent_reg[2]) : crc_reg;

        recent_next[0] = step_byte;
        recent_next[1] = recent_reg[0];
        recent_next[2] = recent_reg[1];

        first_byte_next = (byte_count_reg == POS_HEAD) ? step_byte : first_byte_reg;
        command_next    = (byte_count_reg == POS_COMMAND) ? step_byte : command_reg;
        subcommand_next = (byte_count_reg == POS_SUBCOMMAND) ? step_byte : subcommand_reg;
        if (byte_count_reg == POS_LEN_LO)
        begin
            decl_len_next = {8'h00, step_byte};
        end
        else if (byte_count_reg == POS_LEN_HI)
        begin
            decl_len_next = {step_byte, decl_len_reg[7:0]};
        end
        else
        begin
            decl_len_next = decl_len_reg;
        end

        // The two bytes before the tail are the received CRC, low byte first.
        crc_rx = {recent_reg[0], recent_reg[1]};

        priority if (total < FRAME_OVERHEAD)
        begin
            err = ERR_SHORT;
        end
        else if (overlong_next || (total > max_frame_len))
        begin
            err = ERR_TOO_LONG;
        end
        else if (first_byte_next != HEAD_BYTE)
        begin
            err = ERR_HEAD;
        end
        else if (step_byte != TAIL_BYTE)
        begin
            err = ERR_TAIL;
        end
        else if (crc_rx != crc_next)
        begin
            err = ERR_CRC;
        end
        else if (decl_len_next != total)
        begin
            err = ERR_LENGTH;
        end
        else
        begin
            err = ERR_OK;
        end

        in_payload = (byte_count_reg >= POS_PAYLOAD)
                  && (({1'b0, byte_count_reg} + {1'b0, CRC_LAG}) < {1'b0, decl_len_next});

        result = '0;
        if (step_last)
        begin
            result.emit       = 1'b1;
            result.out_kind   = KIND_VERDICT;
            result.frame_ok   = (err == ERR_OK);
            result.error_code = err;
            result.command    = command_next;
            result.subcommand = subcommand_next;
            result.payload_len = (err == ERR_OK) ? (total - FRAME_OVERHEAD) : 16'd0;
        end
        else if (in_payload)
        begin
            result.emit         = 1'b1;
            result.out_kind     = KIND_PAYLOAD;
            result.payload_byte = step_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            recent_reg[0]  <= '0;
            recent_reg[1]  <= '0;
            recent_reg[2]  <= '0;
            first_byte_reg <= '0;
            command_reg    <= '0;
            subcommand_reg <= '0;
            decl_len_reg   <= '0;
            overlong_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (step_last)
            begin
                // The verdict closes the frame; start the next one fresh.
                byte_count_reg <= '0;
                crc_reg        <= CRC_INIT;
                recent_reg[0]  <= '0;
                recent_reg[1]  <= '0;
                recent_reg[2]  <= '0;
                first_byte_reg <= '0;
                command_reg    <= '0;
                subcommand_reg <= '0;
                decl_len_reg   <= '0;
                overlong_reg   <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                recent_reg[0]  <= recent_next[0];
                recent_reg[1]  <= recent_next[1];
                recent_reg[2]  <= recent_next[2];
                first_byte_reg <= first_byte_next;
                command_reg    <= command_next;
                subcommand_reg <= subcommand_next;
                decl_len_reg   <= decl_len_next;
                overlong_reg   <= overlong_next;
            end
        end
    end

endmodule

@@ hdl/crc_framed_request_deframer_core.sv @@
// Channel   Direction  Transaction
// req       sink       one frame byte (in_byte) with its end flag (last_byte)
// rsp       source     one payload byte or one end-of-frame verdict
// cfg       write      max_frame_len, taken on every cycle with cfg_we high
//
// A byte is taken every cycle unless a waiting result stalls the input register;
// each byte is held there, and any result it yields then moves to the output register.
// The CRC update of one byte and the verdict checks sit between these two registers.
// A waiting result stalls the input register only if the next byte also yields one.
// Reset clears the frame state and sets max_frame_len to 256.
module crc_framed_request_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    crfd_in_if.sink     req,
    crfd_out_if.source  rsp
);
    import crfd_pkg::*;

    logic [15:0] max_len_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_advance;

    result_t     res;

    logic        rsp_valid_reg;
    result_t     rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign s1_advance = s1_valid_reg && (!res.emit || !rsp_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_byte_reg <= req.in_byte;
            s1_last_reg <= req.last_byte;
        end
    end

    crfd_frame_core u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_advance),
        .step_byte     (s1_byte_reg),
        .step_last     (s1_last_reg),
        .max_frame_len (max_len_reg),
        .result        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_advance && res.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res.emit)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_kind     = rsp_data_reg.out_kind;
    assign rsp.payload_byte = rsp_data_reg.payload_byte;
    assign rsp.frame_ok     = rsp_data_reg.frame_ok;
    assign rsp.error_code   = rsp_data_reg.error_code;
    assign rsp.command      = rsp_data_reg.command;
    assign rsp.subcommand   = rsp_data_reg.subcommand;
    assign rsp.payload_len  = rsp_data_reg.payload_len;

`ifndef ASSERT_OFF
    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_data_reg.out_kind == KIND_VERDICT)
        |-> (rsp_data_reg.frame_ok == (rsp_data_reg.error_code == ERR_OK)))
        else $error("verdict frame_ok disagrees with error_code");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_data_reg.out_kind == KIND_PAYLOAD)
        |-> (!rsp_data_reg.frame_ok && (rsp_data_reg.error_code == ERR_OK)
             && (rsp_data_reg.payload_len == 16'd0)))
        else $error("payload result carries verdict fields");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance
        |=> s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_last_reg))
        else $error("stalled input stage was overwritten");

    a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |=> rsp_valid_reg)
        else $error("pending result was dropped");
`endif

endmodule
